/* src/lac_pkg.sv */
// Shared types and constants of the layer alpha compositing block.
package lac_pkg;

    localparam int COORD_W = 12;
    localparam int COMP_W  = 8;
    localparam int OPAC_W  = 7;
    localparam int PROD_W  = 15;

    // Opacity saturates to this many percent.
    localparam logic [OPAC_W-1:0] OPACITY_MAX = 7'd100;
    // alpha * opacity at full coverage: 255 * 100.
    localparam logic [PROD_W-1:0] COV_DIVISOR = 15'd25500;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COMP_W-1:0]  red;
        logic [COMP_W-1:0]  green;
        logic [COMP_W-1:0]  blue;
        logic [COMP_W-1:0]  alpha;
        logic [OPAC_W-1:0]  opacity;
        logic               visible;
        logic               last_layer;
    } pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic [COMP_W-1:0]  out_red;
        logic [COMP_W-1:0]  out_green;
        logic [COMP_W-1:0]  out_blue;
        logic [COMP_W-1:0]  out_alpha;
    } result_t;

endpackage

/* src/layer_alpha_composite.sv */
// An invisible layer skips the math; a visible layer passes the states DIV, MUL and COL.
// A last layer then adds a serial division (FIN) and the load of the result register (OUT).
// A new layer is taken only back in the idle state. Coverage division, weight multiply and colour
// multiply run bit-serially through shift registers, one bit per cycle.
// Reset (rst_n, asynchronous, active low) clears all sums, the FSM and the result register.
// A result waiting in the result register does not stop the next layer transfer.
module layer_alpha_composite
    import lac_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 12
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pixel_valid,
    output logic    pixel_stall,
    input  pixel_t  pixel,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int CS_W   = FRAC_BITS + 1;
    localparam int SUM_W  = FRAC_BITS + COMP_W;
    localparam int DIV_W  = FRAC_BITS + COMP_W + 1;
    localparam int CNT_MX = (FRAC_BITS > COMP_W) ? FRAC_BITS : COMP_W;
    localparam int CNT_W  = $clog2(CNT_MX + 1);
    localparam int MASK_W = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << MASK_W) - 64'd1);
    localparam logic [CS_W-1:0]    ONE_FX     = CS_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_COL,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    pixel_t              pix_reg, pix_next;
    logic [PROD_W-1:0]   rem_reg, rem_next;
    logic [CS_W-1:0]     cov_reg, cov_next;
    logic [CS_W-1:0]     acc_reg, acc_next;
    logic [CS_W-1:0]     cs_reg, cs_next;
    logic [DIV_W-1:0]    sh_reg, sh_next;
    logic [SUM_W-1:0]    red_sum_reg, red_sum_next;
    logic [SUM_W-1:0]    green_sum_reg, green_sum_next;
    logic [SUM_W-1:0]    blue_sum_reg, blue_sum_next;
    logic [2:0]          sat_reg, sat_next;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic [OPAC_W-1:0]   opsat;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W:0]     dbl;
    logic                dbl_ge;
    logic [CS_W-1:0]     rest;
    logic [CS_W-1:0]     part;
    logic [CS_W:0]       mul_sum;
    logic [DIV_W-1:0]    fin_div;
    logic [DIV_W-1:0]    alpha_prod;
    logic                ge_red, ge_green, ge_blue;
    logic                cov_zero;

    // Coverage numerator and remainder step of the serial divide by 25500
    assign opsat   = (pixel.opacity > OPACITY_MAX) ? OPACITY_MAX : pixel.opacity;
    assign prod    = PROD_W'(pixel.alpha) * PROD_W'(opsat);
    assign dbl     = (cnt_reg == CNT_W'(FRAC_BITS)) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign dbl_ge  = dbl >= {1'b0, COV_DIVISOR};

    // Weight multiply, LSB first: rest * coverage bit
    assign rest    = ONE_FX - cs_reg;
    assign part    = cov_reg[0] ? rest : '0;
    assign mul_sum = {1'b0, acc_reg} + {1'b0, part};

    // Final division and alpha scaling
    assign fin_div    = {cs_reg, 8'h00};
    assign alpha_prod = fin_div - DIV_W'(cs_reg);
    assign ge_red     = {1'b0, red_sum_reg} >= sh_reg;
    assign ge_green   = {1'b0, green_sum_reg} >= sh_reg;
    assign ge_blue    = {1'b0, blue_sum_reg} >= sh_reg;
    assign cov_zero   = (cs_reg == '0);

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        pix_next          = pix_reg;
        rem_next          = rem_reg;
        cov_next          = cov_reg;
        acc_next          = acc_reg;
        cs_next           = cs_reg;
        sh_next           = sh_reg;
        red_sum_next      = red_sum_reg;
        green_sum_next    = green_sum_reg;
        blue_sum_next     = blue_sum_reg;
        sat_next          = sat_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        case (state_reg)
            ST_IDLE:
            begin
                // Take a layer transfer; invisible layers skip the math
                if (pixel_valid)
                begin
                    pix_next = pixel;
                    if (pixel.visible)
                    begin
                        rem_next   = prod;
                        cnt_next   = CNT_W'(FRAC_BITS);
                        state_next = ST_DIV;
                    end
                    else if (pixel.last_layer)
                    begin
                        sh_next    = fin_div;
                        cnt_next   = CNT_W'(COMP_W);
                        state_next = ST_FIN;
                    end
                end
            end
            ST_DIV:
            begin
                // One quotient bit of coverage per cycle, MSB first
                rem_next = PROD_W'(dbl_ge ? (dbl - {1'b0, COV_DIVISOR}) : dbl);
                cov_next = {cov_reg[CS_W-2:0], dbl_ge};
                if (cnt_reg == '0)
                begin
                    acc_next   = '0;
                    cnt_next   = CNT_W'(FRAC_BITS);
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_MUL:
            begin
                // Shift out fraction bits; the integer bit adds without a shift
                cov_next = cov_reg >> 1;
                if (cnt_reg == '0)
                begin
                    cs_next    = cs_reg + mul_sum[CS_W-1:0];
                    sh_next    = DIV_W'(mul_sum[CS_W-1:0]);
                    cnt_next   = CNT_W'(COMP_W - 1);
                    state_next = ST_COL;
                end
                else
                begin
                    acc_next = mul_sum[CS_W:1];
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_COL:
            begin
                // Accumulate weight * component, one component bit per cycle
                if (pix_reg.red[0])
                begin
                    red_sum_next = red_sum_reg + sh_reg[SUM_W-1:0];
                end
                if (pix_reg.green[0])
                begin
                    green_sum_next = green_sum_reg + sh_reg[SUM_W-1:0];
                end
                if (pix_reg.blue[0])
                begin
                    blue_sum_next = blue_sum_reg + sh_reg[SUM_W-1:0];
                end
                pix_next.red   = pix_reg.red >> 1;
                pix_next.green = pix_reg.green >> 1;
                pix_next.blue  = pix_reg.blue >> 1;
                sh_next        = sh_reg << 1;
                if (cnt_reg == '0)
                begin
                    if (pix_reg.last_layer)
                    begin
                        sh_next    = fin_div;
                        cnt_next   = CNT_W'(COMP_W);
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_FIN:
            begin
                // First step flags overflow, then restoring division into the
                // component registers
                if (cnt_reg == CNT_W'(COMP_W))
                begin
                    sat_next = {ge_red, ge_green, ge_blue};
                end
                else
                begin
                    if (ge_red)
                    begin
                        red_sum_next = red_sum_reg - sh_reg[SUM_W-1:0];
                    end
                    if (ge_green)
                    begin
                        green_sum_next = green_sum_reg - sh_reg[SUM_W-1:0];
                    end
                    if (ge_blue)
                    begin
                        blue_sum_next = blue_sum_reg - sh_reg[SUM_W-1:0];
                    end
                    pix_next.red   = {pix_reg.red[COMP_W-2:0], ge_red};
                    pix_next.green = {pix_reg.green[COMP_W-2:0], ge_green};
                    pix_next.blue  = {pix_reg.blue[COMP_W-2:0], ge_blue};
                end
                sh_next = sh_reg >> 1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_OUT:
            begin
                // Load the result register once it is free, then clear the sums
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next     = 1'b1;
                    result_next.out_col   = pix_reg.col & COORD_MASK;
                    result_next.out_row   = pix_reg.row & COORD_MASK;
                    result_next.out_red   = cov_zero ? '0 : (sat_reg[2] ? '1 : pix_reg.red);
                    result_next.out_green = cov_zero ? '0 : (sat_reg[1] ? '1 : pix_reg.green);
                    result_next.out_blue  = cov_zero ? '0 : (sat_reg[0] ? '1 : pix_reg.blue);
                    result_next.out_alpha = alpha_prod[FRAC_BITS +: COMP_W];
                    cs_next               = '0;
                    red_sum_next          = '0;
                    green_sum_next        = '0;
                    blue_sum_next         = '0;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            pix_reg          <= '0;
            rem_reg          <= '0;
            cov_reg          <= '0;
            acc_reg          <= '0;
            cs_reg           <= '0;
            sh_reg           <= '0;
            red_sum_reg      <= '0;
            green_sum_reg    <= '0;
            blue_sum_reg     <= '0;
            sat_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            pix_reg          <= pix_next;
            rem_reg          <= rem_next;
            cov_reg          <= cov_next;
            acc_reg          <= acc_next;
            cs_reg           <= cs_next;
            sh_reg           <= sh_next;
            red_sum_reg      <= red_sum_next;
            green_sum_reg    <= green_sum_next;
            blue_sum_reg     <= blue_sum_next;
            sat_reg          <= sat_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign pixel_stall  = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // Total coverage never exceeds one
    a_cov_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cs_reg <= ONE_FX)
        else $error("coverage sum above one");

    // Divider remainder stays below the divisor after the first step
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg != CNT_W'(FRAC_BITS)) |-> (rem_reg < COV_DIVISOR))
        else $error("coverage remainder out of range");

    // A new result leaves the block idle with cleared sums
    a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> (state_reg == ST_IDLE && cs_reg == '0
                                     && red_sum_reg == '0))
        else $error("state not cleared after result");

    // A fresh result comes only from the output state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_stall) |=>
            (!result_valid_reg || $past(state_reg == ST_OUT)))
        else $error("result loaded outside output state");
`endif

endmodule

/* test/tb_layer_alpha_composite.sv */
// Testbench for layer_alpha_composite: layer stacks against a cycle-free compositing predictor.
module tb_layer_alpha_composite
    import lac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC          = 16;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int TAIL_CYCLES   = 64;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_LAYERS = 1600;

    logic    clk;
    logic    rst_n;
    logic    pixel_valid;
    logic    pixel_stall;
    pixel_t  pixel;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    // Predictor state: running coverage (Q1.16) and weighted colour sums
    bit [16:0] cov_acc;
    bit [24:0] red_acc;
    bit [24:0] green_acc;
    bit [24:0] blue_acc;

    result_t expected_pixels[$];
    int      fail_count;
    int      burst_left;
    int      hold_left;
    bit      send_idle_en;
    bit      recv_idle_en;

    layer_alpha_composite i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Divide a colour sum by total coverage; zero coverage gives zero colour
    function automatic logic [COMP_W-1:0] mean_of(bit [24:0] sum, bit [16:0] cov);
        longint unsigned q;
        if (cov == 0)
            return '0;
        q = longint'(sum) / longint'(cov);
        return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    // Fold one accepted layer into the running sums; queue a pixel on the last layer
    function automatic void composite_layer(pixel_t p);
        longint unsigned opac;
        longint unsigned cov;
        longint unsigned rest;
        longint unsigned w;
        longint unsigned a_out;
        result_t         px;
        opac = (p.opacity > OPACITY_MAX) ? longint'(OPACITY_MAX) : longint'(p.opacity);
        if (p.visible)
        begin
            cov  = (longint'(p.alpha) * opac * (64'd1 << FRAC)) / 64'd25500;
            rest = (64'd1 << FRAC) - longint'(cov_acc);
            w    = (rest * cov) >> FRAC;
            cov_acc   = 17'(longint'(cov_acc) + w);
            red_acc   = 25'(longint'(red_acc) + w * longint'(p.red));
            green_acc = 25'(longint'(green_acc) + w * longint'(p.green));
            blue_acc  = 25'(longint'(blue_acc) + w * longint'(p.blue));
        end
        if (p.last_layer)
        begin
            a_out = (longint'(cov_acc) * 64'd255) >> FRAC;
            px.out_col   = p.col;
            px.out_row   = p.row;
            px.out_red   = mean_of(red_acc, cov_acc);
            px.out_green = mean_of(green_acc, cov_acc);
            px.out_blue  = mean_of(blue_acc, cov_acc);
            px.out_alpha = (a_out > 255) ? 8'd255 : 8'(a_out);
            expected_pixels = {expected_pixels, px};
            cov_acc   = '0;
            red_acc   = '0;
            green_acc = '0;
            blue_acc  = '0;
        end
    endfunction

    function automatic pixel_t make_layer(int c, int r, int red, int grn, int blu, int a,
                                          int op, bit vis, bit last);
        pixel_t p;
        p.col        = COORD_W'(c);
        p.row        = COORD_W'(r);
        p.red        = COMP_W'(red);
        p.green      = COMP_W'(grn);
        p.blue       = COMP_W'(blu);
        p.alpha      = COMP_W'(a);
        p.opacity    = OPAC_W'(op);
        p.visible    = vis;
        p.last_layer = last;
        return p;
    endfunction

    // Random layer content, biased toward the alpha and opacity extremes
    function automatic pixel_t random_layer(int c, int r, bit last);
        int a;
        int op;
        int pick;
        pick = $urandom_range(0, 9);
        a  = (pick < 2) ? 255 : (pick < 3) ? 0 : $urandom_range(0, 255);
        pick = $urandom_range(0, 9);
        op = (pick < 6) ? $urandom_range(0, 100) : (pick < 8) ? 100 :
             (pick < 9) ? $urandom_range(101, 127) : 0;
        return make_layer(c, r, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), a, op, $urandom_range(0, 9) != 0, last);
    endfunction

    // Offer one layer, honoring burst gaps, and hold it until the transfer
    task automatic send_layer(pixel_t p);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = send_idle_en ? $urandom_range(0, 12) : 0;
            if (gap > 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        pixel       <= p;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        composite_layer(p);
        @(negedge clk);
    endtask

    // Send one pixel's stack; coordinates sometimes differ between layers
    task automatic send_stack(int depth, inout int counted);
        int  c;
        int  r;
        bit  scramble;
        pixel_t p;
        c = $urandom_range(0, 4095);
        r = $urandom_range(0, 4095);
        scramble = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < depth; i++)
        begin
            if (scramble)
            begin
                c = $urandom_range(0, 4095);
                r = $urandom_range(0, 4095);
            end
            p = random_layer(c, r, i == depth - 1);
            send_layer(p);
            if (p.visible || p.last_layer)
                counted++;
        end
    endtask

    task automatic wait_all_results();
        pixel_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_layer(make_layer(4095, 4095, 255, 255, 255, 255, 100, 1, 1));
        send_layer(make_layer(0, 0, 0, 0, 0, 255, 100, 1, 1));
        // zero alpha and zero opacity give zero coverage
        send_layer(make_layer(1, 2, 200, 100, 50, 0, 100, 1, 1));
        send_layer(make_layer(3, 4, 255, 255, 255, 255, 0, 1, 1));
        // invisible last layer alone
        send_layer(make_layer(5, 6, 9, 9, 9, 255, 100, 0, 1));
        // opacity above 100 saturates
        send_layer(make_layer(7, 8, 128, 64, 32, 200, 127, 1, 1));
        // half red over opaque blue, coordinates differ between layers
        send_layer(make_layer(10, 10, 255, 0, 0, 128, 100, 1, 0));
        send_layer(make_layer(11, 12, 0, 0, 255, 255, 100, 1, 1));
        // invisible middle layer, invisible last layer after visible ones
        send_layer(make_layer(20, 21, 0, 255, 0, 255, 50, 1, 0));
        send_layer(make_layer(20, 21, 255, 255, 255, 255, 100, 0, 0));
        send_layer(make_layer(20, 21, 0, 0, 0, 0, 0, 0, 1));
        // opaque front layer leaves no weight for the back
        send_layer(make_layer(30, 31, 170, 85, 42, 255, 100, 1, 0));
        send_layer(make_layer(30, 31, 255, 255, 255, 255, 100, 1, 1));
        // tiny coverage on both layers
        send_layer(make_layer(40, 41, 255, 1, 128, 1, 1, 1, 0));
        send_layer(make_layer(40, 41, 3, 254, 127, 1, 1, 1, 1));
        wait_all_results();
    endtask

    task automatic test_random(int target, bit idle_en);
        int counted;
        int depth;
        counted      = 0;
        send_idle_en = idle_en;
        recv_idle_en = idle_en;
        while (counted < target)
        begin
            depth = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            send_stack(depth, counted);
        end
    endtask

    // Hold the receiver off long enough that the block backs up its input
    task automatic test_backpressure();
        int counted;
        counted      = 0;
        send_idle_en = 1'b0;
        @(posedge clk);
        hold_left = LONG_HOLD;
        @(negedge clk);
        while (counted < 40)
            send_stack(1, counted);
        wait_all_results();
    endtask

    // Let everything drain between bursts of stacks
    task automatic test_drain_pause();
        int counted;
        counted = 0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            send_stack($urandom_range(1, 4), counted);
            wait_all_results();
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result transfer with the oldest expected pixel
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result at col %0d row %0d", result.out_col,
                           result.out_row);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("out_col", want.out_col, result.out_col);
                    check_field("out_row", want.out_row, result.out_row);
                    check_field("out_red", want.out_red, result.out_red);
                    check_field("out_green", want.out_green, result.out_green);
                    check_field("out_blue", want.out_blue, result.out_blue);
                    check_field("out_alpha", want.out_alpha, result.out_alpha);
                end
            end
        end
    end

    // Drive result stall: long hold-offs first, then random runs when enabled
    initial
    begin
        int run_left;
        bit stall_now;
        run_left     = 0;
        stall_now    = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (!recv_idle_en)
                result_stall <= 1'b0;
            else
            begin
                if (run_left == 0)
                begin
                    stall_now = ($urandom_range(0, 2) == 0);
                    run_left  = $urandom_range(1, 10);
                end
                run_left--;
                result_stall <= stall_now;
            end
        end
    end

    // End the run when no transfer happens for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_MAX)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        pixel        = '0;
        fail_count   = 0;
        burst_left   = 0;
        hold_left    = 0;
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        cov_acc      = '0;
        red_acc      = '0;
        green_acc    = '0;
        blue_acc     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(RANDOM_LAYERS / 2, 1'b1);
        test_backpressure();
        test_random(RANDOM_LAYERS / 5, 1'b0);
        test_drain_pause();
        test_random(RANDOM_LAYERS * 3 / 10, 1'b1);

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
